FILE: sv/att_pkg.sv
// att_pkg: shared types, scale constants and sequencer codes for the tilt angle core
// no dependencies
`timescale 1ns / 1ps

package att_pkg;

    localparam int unsigned W_AXIS = 16;
    localparam int unsigned W_WORD = 34;
    localparam int unsigned W_PROD = 32;
    localparam int unsigned W_TILT = 7;
    localparam int unsigned W_DEN  = 25;
    localparam int unsigned W_NUM  = 30;
    localparam int unsigned W_QUO  = 6;
    localparam int unsigned W_CNT  = 5;
    localparam int unsigned W_ST   = 3;

    typedef logic [W_AXIS-1:0]        t_mag16;
    typedef logic [W_WORD-1:0]        t_word;
    typedef logic [W_PROD-1:0]        t_prod;
    typedef logic signed [W_TILT-1:0] t_tilt;
    typedef logic [W_DEN-1:0]         t_den;
    typedef logic [W_NUM-1:0]         t_num;
    typedef logic [W_QUO-1:0]         t_quo;
    typedef logic [W_CNT-1:0]         t_cnt;
    typedef logic [W_ST-1:0]          t_state;

    localparam t_mag16 SCALE_NUM = 16'd18000;
    localparam t_mag16 SCALE_DEN = 16'd314;

    localparam t_cnt SQ_LAST    = 5'd3;
    localparam t_cnt SQRT_FIRST = 5'd16;
    localparam t_cnt DIV_FIRST  = 5'd5;

    localparam t_state ST_IDLE = 3'd0;
    localparam t_state ST_SQ   = 3'd1;
    localparam t_state ST_SQRT = 3'd2;
    localparam t_state ST_DEN  = 3'd3;
    localparam t_state ST_NUM  = 3'd4;
    localparam t_state ST_DIV  = 3'd5;
    localparam t_state ST_DONE = 3'd6;

endpackage

FILE: sv/att_mul.sv
// att_mul: shared 16 x 16 unsigned multiplier for squares, magnitude scale and axis scale
// depends on att_pkg
`timescale 1ns / 1ps

module att_mul (
    input  att_pkg::t_mag16 i_a,
    input  att_pkg::t_mag16 i_b,
    output att_pkg::t_prod  o_p
);
    import att_pkg::*;

    assign o_p = t_prod'(i_a) * t_prod'(i_b);

endmodule

FILE: sv/att_cmpsub.sv
// att_cmpsub: shared 34-bit compare and subtract unit for square root and division steps
// depends on att_pkg
`timescale 1ns / 1ps

module att_cmpsub (
    input  att_pkg::t_word i_a,
    input  att_pkg::t_word i_b,
    output logic           o_ge,
    output att_pkg::t_word o_diff
);
    import att_pkg::*;

    logic [W_WORD:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W_WORD];
    assign o_diff = w_sub[W_WORD-1:0];

endmodule

FILE: sv/accel_tilt_angle_core.sv
// accel_tilt_angle_core: tilt angles of an accelerometer sample in whole degrees;
// the sequencer forms the sum of squares, runs the square root digit loop and scales the
// magnitude, then, unless it is zero, scales each axis and runs a 6-step division,
// and last loads the output; one sample in flight, and a new sample is taken only once the
// result is loaded, as the multiplier and compare-subtract unit are shared; synchronous
// active-low reset clears the sequencer, the output valid and the held tilts
`timescale 1ns / 1ps

module accel_tilt_angle_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    output logic                o_valid,
    input  logic                i_ready,
    output att_pkg::t_tilt      o_tilt_x,
    output att_pkg::t_tilt      o_tilt_y,
    output logic                o_magnitude_zero
);
    import att_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    logic   r_sel, n_sel;
    logic   r_sx, n_sx, r_sy, n_sy;
    t_mag16 r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    t_prod  r_prod, n_prod;
    t_word  r_sum, n_sum;
    t_word  r_root, n_root;
    t_den   r_den, n_den;
    t_num   r_rem, n_rem;
    t_quo   r_q, n_q;
    t_tilt  r_tx, n_tx, r_ty, n_ty;
    logic   r_zero, n_zero;
    t_tilt  r_held_x, n_held_x, r_held_y, n_held_y;
    logic   r_flag, n_flag;
    logic   r_out_valid, n_out_valid;

    t_mag16 w_mul_a, w_mul_b;
    t_prod  w_mul_p;
    t_word  w_cs_a, w_cs_b, w_cs_diff;
    logic   w_cs_ge;
    t_word  w_bit;
    t_quo   w_q_next;
    t_tilt  w_tilt;

    function automatic t_mag16 f_abs(input logic signed [15:0] v);
        t_mag16 u;
        u = t_mag16'(v);
        return v[15] ? (~u + 16'd1) : u;
    endfunction

    att_mul u_mul (
        .i_a (w_mul_a),
        .i_b (w_mul_b),
        .o_p (w_mul_p)
    );

    att_cmpsub u_cmpsub (
        .i_a    (w_cs_a),
        .i_b    (w_cs_b),
        .o_ge   (w_cs_ge),
        .o_diff (w_cs_diff)
    );

    // shared unit operand selection
    always_comb begin
        w_mul_a = r_az;
        w_mul_b = r_az;
        w_cs_a  = r_sum;
        w_bit   = t_word'(1) << {r_cnt, 1'b0};
        w_cs_b  = r_root + w_bit;
        case (r_state)
            ST_SQ: begin
                case (r_cnt)
                    5'd0: begin
                        w_mul_a = r_ax;
                        w_mul_b = r_ax;
                    end
                    5'd1: begin
                        w_mul_a = r_ay;
                        w_mul_b = r_ay;
                    end
                    default: begin
                        w_mul_a = r_az;
                        w_mul_b = r_az;
                    end
                endcase
            end
            ST_DEN: begin
                w_mul_a = r_root[W_AXIS-1:0];
                w_mul_b = SCALE_DEN;
            end
            ST_NUM: begin
                w_mul_a = r_sel ? r_ay : r_ax;
                w_mul_b = SCALE_NUM;
            end
            ST_DIV: begin
                w_cs_a = t_word'(r_rem);
                w_cs_b = t_word'(r_den) << r_cnt[2:0];
            end
            default: begin
                w_mul_a = r_az;
            end
        endcase
    end

    assign w_q_next = {r_q[W_QUO-2:0], w_cs_ge};
    assign w_tilt   = (r_sel ? r_sy : r_sx) ? (~t_tilt'({1'b0, w_q_next}) + 7'sd1)
                                            : t_tilt'({1'b0, w_q_next});

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sel       = r_sel;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_az        = r_az;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_root      = r_root;
        n_den       = r_den;
        n_rem       = r_rem;
        n_q         = r_q;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_zero      = r_zero;
        n_held_x    = r_held_x;
        n_held_y    = r_held_y;
        n_flag      = r_flag;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_sx    = i_accel_x[15];
                    n_sy    = i_accel_y[15];
                    n_ax    = f_abs(i_accel_x);
                    n_ay    = f_abs(i_accel_y);
                    n_az    = f_abs(i_accel_z);
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                n_prod = w_mul_p;
                if (r_cnt != 5'd0) begin
                    n_sum = r_sum + t_word'(r_prod);
                end
                if (r_cnt == SQ_LAST) begin
                    n_root  = '0;
                    n_cnt   = SQRT_FIRST;
                    n_state = ST_SQRT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_SQRT: begin
                if (w_cs_ge) begin
                    n_sum  = w_cs_diff;
                    n_root = (r_root >> 1) + w_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                if (r_cnt == 5'd0) begin
                    n_state = ST_DEN;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_DEN: begin
                n_den  = w_mul_p[W_DEN-1:0];
                n_zero = (r_root == '0);
                n_sel  = 1'b0;
                n_state = (r_root == '0) ? ST_DONE : ST_NUM;
            end
            ST_NUM: begin
                n_rem   = w_mul_p[W_NUM-1:0];
                n_q     = '0;
                n_cnt   = DIV_FIRST;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_cs_ge) begin
                    n_rem = w_cs_diff[W_NUM-1:0];
                end
                n_q = w_q_next;
                if (r_cnt == 5'd0) begin
                    if (r_sel) begin
                        n_ty    = w_tilt;
                        n_state = ST_DONE;
                    end else begin
                        n_tx    = w_tilt;
                        n_sel   = 1'b1;
                        n_state = ST_NUM;
                    end
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    if (!r_zero) begin
                        n_held_x = r_tx;
                        n_held_y = r_ty;
                    end
                    n_flag      = r_zero;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_flag      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_held_x    <= n_held_x;
            r_held_y    <= n_held_y;
            r_flag      <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_sel  <= n_sel;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_az   <= n_az;
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_root <= n_root;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_tx   <= n_tx;
        r_ty   <= n_ty;
        r_zero <= n_zero;
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_tilt_x         = r_held_x;
    assign o_tilt_y         = r_held_y;
    assign o_magnitude_zero = r_flag;

endmodule

FILE: sv/att_checker.sv
// att_checker: port-level assertions for accel_tilt_angle_core, with its bind
// depends on att_pkg and accel_tilt_angle_core
`timescale 1ns / 1ps

module att_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic signed [15:0]  i_accel_x,
    input logic signed [15:0]  i_accel_y,
    input logic signed [15:0]  i_accel_z,
    input logic                o_valid,
    input logic                i_ready,
    input att_pkg::t_tilt      o_tilt_x,
    input att_pkg::t_tilt      o_tilt_y,
    input logic                o_magnitude_zero
);
    import att_pkg::*;

    // result beat held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tilt_x) && $stable(o_tilt_y))
        else $error("result beat dropped or changed while stalled");

    // a zero sample repeats the held tilts
    a_zero_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_magnitude_zero |-> $stable(o_tilt_x) && $stable(o_tilt_y))
        else $error("held tilts changed on zero magnitude");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tilt_x >= -7'sd57) && (o_tilt_x <= 7'sd57)
                 && (o_tilt_y >= -7'sd57) && (o_tilt_y <= 7'sd57))
        else $error("tilt out of range");

    // one sample in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while busy");

endmodule

bind accel_tilt_angle_core att_checker u_att_checker (.*);
